[sv/ple_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine package
// Field widths, request and status codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package ple_pkg;

	// field widths
	localparam int KW = 2;
	localparam int PW = 5;
	localparam int VW = 32;
	localparam int SW = 2;

	// default list capacity
	localparam int CAPACITY_DEF = 16;

	// request kinds
	localparam logic [KW-1:0] K_INSERT = 2'd0;
	localparam logic [KW-1:0] K_DELETE = 2'd1;
	localparam logic [KW-1:0] K_LOCATE = 2'd2;

	// result status codes
	localparam logic [SW-1:0] ST_OK     = 2'd0;
	localparam logic [SW-1:0] ST_FULL   = 2'd1;
	localparam logic [SW-1:0] ST_EMPTY  = 2'd2;
	localparam logic [SW-1:0] ST_BADPOS = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture request, check it, set up the walk
		logic walk;    // one step of the entry walk
		logic put;     // write the inserted value
		logic finish;  // commit length, load the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_done;   // no reads left, or locate hit
		logic put_needed;  // accepted insert
		logic out_free;    // output register can take a beat
	} sts_t;

endpackage

[sv/ple_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ple_req_if import ple_pkg::*; ;
	logic          valid;
	logic          ready;
	logic [KW-1:0] kind;
	logic [PW-1:0] position;
	logic signed [VW-1:0] value;

	modport source (output valid, kind, position, value, input ready);
	modport sink   (input valid, kind, position, value, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ;
	logic          valid;
	logic          ready;
	logic [SW-1:0] status;
	logic signed [VW-1:0] removed_value;
	logic [PW-1:0] found_position;
	logic [PW-1:0] list_length;

	modport source (output valid, status, removed_value, found_position, list_length,
		input ready);
	modport sink   (input valid, status, removed_value, found_position, list_length,
		output ready);
endinterface

[sv/ple_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine controller
// Sequences accept, entry walk, insert write and result hand-off.
// ----------------------------------------------------------------------------
module ple_ctrl import ple_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_PUT  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					state_d = sts.put_needed ? S_PUT : S_DONE;
				end
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/ple_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine datapath
// Entry memory, request checks, shift/search walk and output register.
// ----------------------------------------------------------------------------
module ple_datapath import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	output sts_t          sts,
	input  logic [KW-1:0] kind,
	input  logic [PW-1:0] position,
	input  logic [VW-1:0] value,
	input  logic          rsp_ready,
	output logic          rsp_valid,
	output logic [SW-1:0] status,
	output logic [VW-1:0] removed_value,
	output logic [PW-1:0] found_position,
	output logic [PW-1:0] list_length
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int XW = ((CW > PW) ? CW : PW) + 1;

	// entry store
	logic [VW-1:0] mem [CAPACITY];
	logic [VW-1:0] rdata_q;

	// request and walk registers
	logic [KW-1:0] kind_q;
	logic [VW-1:0] val_q;
	logic [AW-1:0] pos0_q;
	logic [SW-1:0] st_q;
	logic          ok_q;
	logic [CW-1:0] rem_q;
	logic [AW-1:0] rp_q;
	logic [AW-1:0] last_q;
	logic          pend_q;
	logic [VW-1:0] removed_q;
	logic [PW-1:0] found_q;
	logic [CW-1:0] count_q;

	// output register
	logic          ovld_q;
	logic [SW-1:0] o_status_q;
	logic [VW-1:0] o_removed_q;
	logic [PW-1:0] o_found_q;
	logic [PW-1:0] o_len_q;

	logic [XW-1:0] cnt_x, pos_x;
	logic [SW-1:0] ld_st;
	logic          ld_ok;
	logic [CW-1:0] ld_rem;
	logic [AW-1:0] ld_rp;
	logic          is_ins, is_del, is_loc;
	logic          hit, issue, we;
	logic [AW-1:0] waddr;
	logic [VW-1:0] wdata;
	logic [CW-1:0] nxt_cnt;

	assign cnt_x = XW'(count_q);
	assign pos_x = XW'(position);

	// request checks at accept
	always_comb begin
		ld_st  = ST_OK;
		ld_ok  = 1'b0;
		ld_rem = '0;
		ld_rp  = '0;
		case (kind)
			K_INSERT: begin
				if (cnt_x >= XW'(CAPACITY)) begin
					ld_st = ST_FULL;
				end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
					ld_st = ST_BADPOS;
				end else begin
					ld_ok  = 1'b1;
					ld_rem = CW'(cnt_x - pos_x + XW'(1));
					ld_rp  = AW'(cnt_x - XW'(1));
				end
			end
			K_DELETE: begin
				if (count_q == '0) begin
					ld_st = ST_EMPTY;
				end else if (pos_x == '0 || pos_x > cnt_x) begin
					ld_st = ST_BADPOS;
				end else begin
					ld_ok  = 1'b1;
					ld_rem = CW'(cnt_x - pos_x + XW'(1));
					ld_rp  = AW'(pos_x - XW'(1));
				end
			end
			K_LOCATE: begin
				ld_rem = count_q;
			end
			default: begin
			end
		endcase
	end

	// walk step: insert reads downwards and writes one up, delete reads
	// upwards and writes one down, locate compares
	assign is_ins = (kind_q == K_INSERT);
	assign is_del = (kind_q == K_DELETE);
	assign is_loc = (kind_q == K_LOCATE);
	assign hit    = pend_q && is_loc && (rdata_q == val_q);
	assign issue  = cmd.walk && (rem_q != '0) && !hit;
	assign we     = cmd.put ||
		(cmd.walk && pend_q && (is_ins || (is_del && last_q != pos0_q)));
	assign waddr  = cmd.put ? pos0_q : (is_ins ? last_q + AW'(1) : last_q - AW'(1));
	assign wdata  = cmd.put ? val_q : rdata_q;

	always_comb begin
		nxt_cnt = count_q;
		if (ok_q && is_ins) begin
			nxt_cnt = count_q + CW'(1);
		end else if (ok_q && is_del) begin
			nxt_cnt = count_q - CW'(1);
		end
	end

	assign sts.walk_done  = ((rem_q == '0) && !pend_q) || hit;
	assign sts.put_needed = is_ins && ok_q;
	assign sts.out_free   = !ovld_q || rsp_ready;

	// memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (issue) begin
			rdata_q <= mem[rp_q];
		end
	end

	// request and walk payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind;
			val_q     <= value;
			pos0_q    <= AW'(pos_x - XW'(1));
			st_q      <= ld_st;
			ok_q      <= ld_ok;
			rp_q      <= ld_rp;
			removed_q <= '0;
			found_q   <= '0;
		end else begin
			if (issue) begin
				rp_q   <= is_ins ? rp_q - AW'(1) : rp_q + AW'(1);
				last_q <= rp_q;
			end
			if (cmd.walk && pend_q && is_del && last_q == pos0_q) begin
				removed_q <= rdata_q;
			end
			if (cmd.walk && hit) begin
				found_q <= PW'(XW'(last_q) + XW'(1));
			end
		end
		if (cmd.finish) begin
			o_status_q  <= st_q;
			o_removed_q <= removed_q;
			o_found_q   <= found_q;
			o_len_q     <= PW'(nxt_cnt);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
			pend_q  <= 1'b0;
			ovld_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				rem_q  <= ld_rem;
				pend_q <= 1'b0;
			end else begin
				pend_q <= issue;
				if (issue) begin
					rem_q <= rem_q - CW'(1);
				end
			end
			if (cmd.finish) begin
				count_q <= nxt_cnt;
				ovld_q  <= 1'b1;
			end else if (rsp_ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid      = ovld_q;
	assign status         = o_status_q;
	assign removed_value  = o_removed_q;
	assign found_position = o_found_q;
	assign list_length    = o_len_q;

endmodule

[sv/positional_list_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit entries with insert, delete and locate.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result beat. Entries live in a
// single-port-read memory, so the time per request is set by the walk over
// it, one entry a cycle, then a drain of the registered read. Insert and
// delete walk from position P to the end of the list (an append walks no
// entries), locate walks to the first match or the end of the list, and a
// rejected or unused request, or a locate on an empty list, walks no entries.
// The result sits in an output register; the engine waits before committing
// only if the previous result has not been taken.
// Entry storage is not cleared at reset; only positions inside the list are
// ever read.
module positional_list_engine_unit import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ple_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (req.kind),
		.position       (req.position),
		.value          (req.value),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.status         (rsp.status),
		.removed_value  (rsp.removed_value),
		.found_position (rsp.found_position),
		.list_length    (rsp.list_length)
	);

endmodule

[sv/ple_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input logic [SW-1:0] status,
	input logic [VW-1:0] removed_value,
	input logic [PW-1:0] found_position,
	input logic [PW-1:0] list_length
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
		$stable(removed_value) && $stable(found_position) && $stable(list_length))
		else $error("result beat changed while stalled");

	// a full list reports its capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> list_length == PW'(CAPACITY))
		else $error("full status with wrong length");

	// an empty list reports zero length
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> list_length == '0)
		else $error("empty status with nonzero length");

	// removed and found values only on success, never both
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (removed_value != '0 || found_position != '0) |->
		status == ST_OK && (removed_value == '0 || found_position == '0))
		else $error("removed or found value on a failed or mixed beat");

endmodule

bind positional_list_engine_unit ple_checker #(
	.CAPACITY (CAPACITY)
) u_ple_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.status),
	.removed_value  (rsp.removed_value),
	.found_position (rsp.found_position),
	.list_length    (rsp.list_length)
);
